// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define BCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bcd assertion failed");

// Consequent checked in the cycle after the antecedent.
`define BCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`BCD_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

// File: src/bcd_pkg.sv
package bcd_pkg;

	// Field widths of the configuration registers.
	localparam int IMG_W_BITS    = 11;
	localparam int IMG_H_BITS    = 13;
	localparam int CFG_DATA_BITS = 13;

	// Reset sizes of the image.
	localparam int RST_IMG_W = 640;
	localparam int RST_IMG_H = 480;

	// Configuration register indexes.
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// Input word modes.
	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_DRAIN = 1'b1;

	// Input word.
	typedef struct packed {
		logic mode;
		logic pixel_in;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic pixel_out;
		logic row_end;
		logic frame_end;
	} out_word_t;

	// Bits held by one cell of the line chain: previous row and the row before it.
	typedef struct packed {
		logic row1;
		logic row2;
	} tap_pair_t;

	// Control of the line chain.
	typedef struct packed {
		logic shift;
		logic din;
	} line_ctl_t;

	// Fixed taps at the far end of the line chain.
	typedef struct packed {
		logic cur;
		logic nxt;
		logic up;
	} line_taps_t;

endpackage

// File: src/bcd_if.sv
// Input channel: valid/ready with one pixel word.
interface bcd_in_if import bcd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result channel: valid/ready with one result word.
interface bcd_out_if import bcd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/bcd_cell.sv
// One column of the two line stores. On a shift it loads either the word
// entering the chain (when it is the entry cell) or its left neighbor.
module bcd_cell import bcd_pkg::*; (
	input  logic      clk,
	input  logic      shift,
	input  logic      entry,
	input  tap_pair_t ent,
	input  tap_pair_t prev,
	output tap_pair_t q
);

	tap_pair_t pair_q;

	// Line store contents need no reset.
	always_ff @(posedge clk) begin
		if (shift) begin
			pair_q <= entry ? ent : prev;
		end
	end

	assign q = pair_q;

endmodule

// File: src/bcd_line.sv
// Chain of MAX_WIDTH cells forming two line delays of configurable length.
// New pixels enter at cell start and leave at the last cell after as many
// shifts as the image is wide; the previous row cascades into the second line.
module bcd_line import bcd_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	localparam int PW = $clog2(MAX_WIDTH)
) (
	input  logic          clk,
	input  line_ctl_t     ctl,
	input  logic [PW-1:0] start,
	output line_taps_t    taps
);

	tap_pair_t link [MAX_WIDTH];
	tap_pair_t ent;

	// The entry cell takes the new pixel and the pixel leaving the first line.
	assign ent.row1 = ctl.din;
	assign ent.row2 = link[MAX_WIDTH-1].row1;

	for (genvar p = 0; p < MAX_WIDTH; p++) begin : g_cell
		tap_pair_t prev;

		if (p == 0) begin : g_head
			assign prev = '0;
		end else begin : g_body
			assign prev = link[p-1];
		end

		bcd_cell u_cell (
			.clk   (clk),
			.shift (ctl.shift),
			.entry (start == PW'(p)),
			.ent   (ent),
			.prev  (prev),
			.q     (link[p])
		);
	end

	// Current column, next column of the previous row, and the row above it.
	assign taps.cur = link[MAX_WIDTH-1].row1;
	assign taps.nxt = link[MAX_WIDTH-2].row1;
	assign taps.up  = link[MAX_WIDTH-1].row2;

endmodule

// File: src/binary_cross_dilation.sv
// Channel   Dir  Handshake      Word
// pixels    in   valid/ready    mode, pixel_in
// results   out  valid/ready    pixel_out, row_end, frame_end
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// One word is taken per clock while pixels.ready is high; its result is
// registered. The line stores are a chain of shift cells, one per column,
// so all reads come from fixed taps and there is no read latency to hide.
// arst_n resets counters, sizes and the output valid; line store contents
// are not cleared. pixels.ready drops only while a result waits in the
// output register and results.ready is low.
module binary_cross_dilation import bcd_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	bcd_in_if.sink                   pixels,
	bcd_out_if.source                results
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int RST_W = (RST_IMG_W < MAX_WIDTH) ? RST_IMG_W : MAX_WIDTH;
	localparam int RST_H = (RST_IMG_H < MAX_HEIGHT) ? RST_IMG_H : MAX_HEIGHT;

	logic [CW-1:0] wm1_q;
	logic [CW-1:0] start_q;
	logic [RW-1:0] hm1_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] dcol_q;
	logic          drain_q;
	logic          left_q;
	logic          out_v_q;
	out_word_t     out_q;

	logic [31:0]   w_req;
	logic [31:0]   w_eff;
	logic [31:0]   h_req;
	logic [31:0]   h_eff;

	logic          acc;
	logic          is_pix;
	logic [CW-1:0] x;
	logic          last_col;
	logic          up_ok;
	logic          down;
	logic          has_res;
	out_word_t     res;
	line_ctl_t     ctl;
	line_taps_t    taps;

	// Clamp written sizes into the supported range.
	always_comb begin
		w_req = 32'(cfg_data[IMG_W_BITS-1:0]);
		h_req = 32'(cfg_data[IMG_H_BITS-1:0]);
		if (w_req == 32'd0) begin
			w_eff = 32'd1;
		end else if (w_req > 32'(MAX_WIDTH)) begin
			w_eff = 32'(MAX_WIDTH);
		end else begin
			w_eff = w_req;
		end
		if (h_req == 32'd0) begin
			h_eff = 32'd1;
		end else if (h_req > 32'(MAX_HEIGHT)) begin
			h_eff = 32'(MAX_HEIGHT);
		end else begin
			h_eff = h_req;
		end
	end

	assign acc    = pixels.valid && pixels.ready;
	assign is_pix = (pixels.data.mode == MODE_PIXEL);

	// Cross window around the current output position.
	always_comb begin
		x        = is_pix ? col_q : dcol_q;
		last_col = (x == wm1_q);
		up_ok    = is_pix ? (row_q > RW'(1)) : (hm1_q != '0);
		down     = is_pix & pixels.data.pixel_in;
		has_res  = is_pix ? (row_q != '0) : drain_q;

		res.pixel_out = taps.cur | down | (up_ok & taps.up) | (~last_col & taps.nxt)
			| ((x != '0) & left_q);
		res.row_end   = last_col;
		res.frame_end = ~is_pix & last_col;

		ctl.shift = acc & (is_pix | drain_q);
		ctl.din   = is_pix & pixels.data.pixel_in;
	end

	bcd_line #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.ctl   (ctl),
		.start (start_q),
		.taps  (taps)
	);

	// Sizes, raster position and drain state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm1_q   <= CW'(RST_W - 1);
			start_q <= CW'(MAX_WIDTH - RST_W);
			hm1_q   <= RW'(RST_H - 1);
			col_q   <= '0;
			row_q   <= '0;
			dcol_q  <= '0;
			drain_q <= 1'b0;
			left_q  <= 1'b0;
		end else if (cfg_we) begin
			// A size change restarts the frame.
			if (cfg_index == CFG_IDX_WIDTH) begin
				wm1_q   <= CW'(w_eff - 32'd1);
				start_q <= CW'(32'(MAX_WIDTH) - w_eff);
			end else begin
				hm1_q <= RW'(h_eff - 32'd1);
			end
			col_q   <= '0;
			row_q   <= '0;
			dcol_q  <= '0;
			drain_q <= 1'b0;
			left_q  <= 1'b0;
		end else if (acc) begin
			if (is_pix) begin
				drain_q <= 1'b0;
				left_q  <= taps.cur;
				if (last_col) begin
					col_q  <= '0;
					left_q <= 1'b0;
					if (row_q == hm1_q) begin
						row_q   <= '0;
						drain_q <= 1'b1;
						dcol_q  <= '0;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (drain_q) begin
				left_q <= taps.cur;
				if (last_col) begin
					drain_q <= 1'b0;
				end else begin
					dcol_q <= dcol_q + CW'(1);
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (acc) begin
			out_v_q <= has_res;
		end else if (results.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && has_res) begin
			out_q <= res;
		end
	end

	assign pixels.ready  = !out_v_q || results.ready;
	assign results.valid = out_v_q;
	assign results.data  = out_q;

endmodule

// File: src/bcd_checker.sv
`include "assert_macros.svh"

// Port-level checks of the dilation block.
module bcd_checker import bcd_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      in_mode,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	logic out_row_end;
	logic out_frame_end;

	assign out_row_end   = out_data.row_end;
	assign out_frame_end = out_data.frame_end;

	// A stalled result word holds.
	`BCD_ASSERT(a_hold, clk, arst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
	// The end of a frame is always the end of a row.
	`BCD_ASSERT(a_frame_row, clk, arst_n, out_valid |-> (!out_frame_end || out_row_end))
	// A pixel word never closes a frame.
	`BCD_ASSERT_NEXT(a_pix_no_frame, clk, arst_n, in_valid && in_ready && in_mode == MODE_PIXEL, !(out_valid && out_frame_end))
	// Drain results mark row end and frame end together.
	`BCD_ASSERT_NEXT(a_drain_marks, clk, arst_n, in_valid && in_ready && in_mode == MODE_DRAIN, !out_valid || (out_row_end == out_frame_end))
	// With the output register empty the input is never held off.
	`BCD_ASSERT(a_ready_free, clk, arst_n, !out_valid |-> in_ready)

endmodule

bind binary_cross_dilation bcd_checker u_bcd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixels.valid),
	.in_ready  (pixels.ready),
	.in_mode   (pixels.data.mode),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.data)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
	import bcd_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 4096;
	localparam int CYCLE_LIMIT = 200000;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	bcd_in_if  pixels ();
	bcd_out_if results ();

	binary_cross_dilation #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pixels),
		.results  (results)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Words waiting to be sent and dilated words waiting to come back.
	in_word_t  pixel_words_q[$];
	out_word_t dilated_q[$];

	int errors    = 0;
	int cycles    = 0;
	int idle_pct  = 0;
	int stall_pct = 0;

	// Effective sizes the stimulus generator builds frames for.
	int gen_w;
	int gen_h;

	// Predictor state: sizes, two line halves, raster position and drain count.
	logic [IMG_W_BITS-1:0] pred_w = IMG_W_BITS'(RST_IMG_W);
	logic [IMG_H_BITS-1:0] pred_h = IMG_H_BITS'(RST_IMG_H);
	bit                    line_mem[2*MAX_W];
	int                    cur_col    = 0;
	int                    cur_row    = 0;
	int                    drain_left = 0;
	bit                    left_bit   = 1'b0;

	// A size of zero acts as one and a size over the top acts as the top.
	function automatic int clamp_size(int v, int top);
		if (v < 1)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	// OR over the cross centered at (col, row); the lower neighbor is given.
	// The other half of the line store holds the row above.
	function automatic bit cross_or(int row, int col, int w, bit down);
		bit centre;
		bit v;
		centre = line_mem[(row % 2) * MAX_W + col];
		v = centre | down;
		if (col > 0)
			v |= left_bit;
		if (col + 1 < w)
			v |= line_mem[(row % 2) * MAX_W + col + 1];
		if (row > 0)
			v |= line_mem[((row + 1) % 2) * MAX_W + col];
		left_bit = centre;
		return v;
	endfunction

	// Any register write restarts the frame.
	task automatic apply_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
		if (idx == CFG_IDX_WIDTH)
			pred_w = val[IMG_W_BITS-1:0];
		else
			pred_h = val[IMG_H_BITS-1:0];
		cur_col    = 0;
		cur_row    = 0;
		drain_left = 0;
		left_bit   = 1'b0;
	endtask

	// Advance the predictor by one accepted word and queue what it yields.
	task automatic dilate_word(in_word_t word);
		int        w;
		int        h;
		int        x;
		out_word_t r;
		w = clamp_size(int'(pred_w), MAX_W);
		h = clamp_size(int'(pred_h), MAX_H);
		if (word.mode == MODE_DRAIN) begin
			if (drain_left == 0)
				return;
			if (drain_left > w)
				drain_left = w;
			x = w - drain_left;
			r.pixel_out = cross_or(h - 1, x, w, 1'b0);
			r.row_end   = (x == w - 1);
			r.frame_end = r.row_end;
			drain_left--;
			dilated_q.push_back(r);
			return;
		end
		// A new pixel drops any pending drain.
		drain_left = 0;
		if (cur_col >= w || cur_row >= h) begin
			cur_col = 0;
			cur_row = 0;
		end
		if (cur_row > 0) begin
			r.pixel_out = cross_or(cur_row - 1, cur_col, w, word.pixel_in);
			r.row_end   = (cur_col == w - 1);
			r.frame_end = 1'b0;
			dilated_q.push_back(r);
		end
		line_mem[(cur_row % 2) * MAX_W + cur_col] = word.pixel_in;
		cur_col++;
		if (cur_col >= w) begin
			cur_col  = 0;
			left_bit = 1'b0;
			cur_row++;
			if (cur_row >= h) begin
				cur_row    = 0;
				drain_left = w;
			end
		end
	endtask

	// Driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			pixels.valid <= 1'b0;
		end else begin
			if (pixels.valid && pixels.ready)
				dilate_word(pixels.data);
			if (!pixels.valid || pixels.ready) begin
				if (pixel_words_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					pixels.valid <= 1'b1;
					pixels.data  <= pixel_words_q.pop_front();
				end else begin
					pixels.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: each accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n && results.valid && results.ready) begin
			if (dilated_q.size() == 0) begin
				$error("result word with no prediction waiting");
				errors++;
			end else begin
				want = dilated_q.pop_front();
				if (results.data.pixel_out !== want.pixel_out) begin
					$error("pixel_out: expected %0d, actual %0d",
						want.pixel_out, results.data.pixel_out);
					errors++;
				end
				if (results.data.row_end !== want.row_end) begin
					$error("row_end: expected %0d, actual %0d",
						want.row_end, results.data.row_end);
					errors++;
				end
				if (results.data.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, actual %0d",
						want.frame_end, results.data.frame_end);
					errors++;
				end
			end
		end
		results.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic push_word(logic mode, logic pix);
		in_word_t word;
		word.mode     = mode;
		word.pixel_in = pix;
		pixel_words_q.push_back(word);
	endtask

	// One full frame of random pixels with the given density, then drain words.
	task automatic push_frame(int w, int h, int density, int drains);
		repeat (w * h)
			push_word(MODE_PIXEL, $urandom_range(99) < density);
		repeat (drains)
			push_word(MODE_DRAIN, 1'($urandom_range(1)));
	endtask

	// Wait until nothing is queued, in flight or predicted, plus the output stage.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_words_q.size() != 0 || pixels.valid || dilated_q.size() != 0);
		repeat (4)
			@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_DATA_BITS-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		apply_reg(idx, val);
	endtask

	// Reconfigure both sizes once the block has gone quiet.
	task automatic set_size(logic [CFG_DATA_BITS-1:0] wv, logic [CFG_DATA_BITS-1:0] hv);
		wait_idle();
		write_reg(CFG_IDX_WIDTH, wv);
		write_reg(CFG_IDX_HEIGHT, hv);
		gen_w = clamp_size(int'(wv[IMG_W_BITS-1:0]), MAX_W);
		gen_h = clamp_size(int'(hv[IMG_H_BITS-1:0]), MAX_H);
		@(negedge clk);
	endtask

	// Stimulus: reset, directed frames, then random frames under four idle and stall modes.
	initial begin
		int                       idle_tab[4];
		int                       stall_tab[4];
		int                       m;
		int                       f;
		int                       nfr;
		int                       kind;
		int                       dens;
		int                       n;
		int                       sent;
		logic [CFG_DATA_BITS-1:0] wv;
		logic [CFG_DATA_BITS-1:0] hv;
		idle_tab      = '{0, 82, 0, 14};
		stall_tab     = '{0, 0, 82, 14};
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_IDX_WIDTH;
		cfg_data      = '0;
		pixels.valid  = 1'b0;
		pixels.data   = '0;
		results.ready = 1'b0;
		repeat (11)
			@(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset sizes: a drain with nothing pending, then part of a first row.
		push_word(MODE_DRAIN, 1'b0);
		push_word(MODE_PIXEL, 1'b1);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b1);

		// 3x3 frame with a lone center pixel, full drain and one drain too many.
		set_size(13'd3, 13'd3);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b1);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		repeat (4)
			push_word(MODE_DRAIN, 1'b1);
		// Corner pixels, then a pixel cuts the drain short and starts a new frame.
		push_word(MODE_PIXEL, 1'b1);
		repeat (7)
			push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b1);
		push_word(MODE_DRAIN, 1'b0);
		push_word(MODE_PIXEL, 1'b1);

		// Single-row frame comes out by drain only.
		set_size(13'd4, 13'd1);
		push_word(MODE_PIXEL, 1'b1);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_PIXEL, 1'b1);
		repeat (4)
			push_word(MODE_DRAIN, 1'b0);

		// Zero sizes act as 1x1; the upper width bits are dropped.
		set_size(13'h1800, 13'h0000);
		push_word(MODE_PIXEL, 1'b1);
		push_word(MODE_DRAIN, 1'b1);
		push_word(MODE_DRAIN, 1'b0);
		push_word(MODE_PIXEL, 1'b0);
		push_word(MODE_DRAIN, 1'b1);

		// Widest register value clamps to the maximum width; part of the first row.
		set_size(13'h1FFF, 13'd1);
		repeat (24)
			push_word(MODE_PIXEL, 1'($urandom_range(1)));
		push_word(MODE_DRAIN, 1'b1);
		// Exact maximum width; part of the first row.
		set_size(CFG_DATA_BITS'(MAX_W), 13'd2);
		repeat (24)
			push_word(MODE_PIXEL, 1'($urandom_range(1)));
		// Tallest register value clamps to the maximum height; one pixel per row.
		set_size(13'd1, 13'h1FFF);
		repeat (32)
			push_word(MODE_PIXEL, $urandom_range(99) < 30);
		push_word(MODE_DRAIN, 1'b1);

		// Random frames, mostly well formed, with broken and noisy ones mixed in.
		for (m = 0; m < 4; m++) begin
			sent = 0;
			while (sent < 60) begin
				wv = CFG_DATA_BITS'($urandom_range(1, 9));
				hv = CFG_DATA_BITS'($urandom_range(1, 6));
				if ($urandom_range(11) == 0)
					wv = 0;
				if ($urandom_range(11) == 0)
					hv = 0;
				if ($urandom_range(3) == 0)
					wv[12:11] = 2'($urandom_range(3));
				set_size(wv, hv);
				idle_pct  = idle_tab[m];
				stall_pct = stall_tab[m];
				nfr = $urandom_range(1, 3);
				for (f = 0; f < nfr; f++) begin
					kind = $urandom_range(9);
					dens = $urandom_range(5, 60);
					if (kind == 9) begin
						// Raw noise leaves the raster misaligned, so it ends the set.
						n = $urandom_range(1, 2 * gen_w);
						repeat (n)
							push_word(1'($urandom_range(1)), 1'($urandom_range(1)));
						sent += n;
						break;
					end
					if (kind == 0)
						push_word(MODE_DRAIN, 1'($urandom_range(1)));
					if (kind == 7)
						push_frame(gen_w, gen_h, dens, $urandom_range(0, gen_w - 1));
					else if (kind == 8)
						push_frame(gen_w, gen_h, dens, gen_w + $urandom_range(1, 3));
					else
						push_frame(gen_w, gen_h, dens, gen_w);
					sent += gen_w * gen_h;
				end
			end
		end

		wait_idle();
		repeat (8)
			@(posedge clk);
		if (dilated_q.size() != 0) begin
			$error("%0d predicted result words never arrived", dilated_q.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/bcd_pkg.sv
src/bcd_if.sv
src/bcd_cell.sv
src/bcd_line.sv
src/binary_cross_dilation.sv
src/bcd_checker.sv
test/tb.sv
